// File: sv/assert_macros.svh
// Assertion helpers shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define LPRD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define LPRD_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define LPRD_ASSERT(lbl, clk, rst_n, prop, msg)
`define LPRD_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: sv/lprd_pkg.sv
package lprd_pkg;

  // Command codes that open a keyed frame
  localparam logic [7:0] CMD_STORE  = 8'd11;
  localparam logic [7:0] CMD_FETCH  = 8'd12;
  localparam logic [7:0] CMD_DELETE = 8'd13;

  // Byte roles
  localparam logic [2:0] ROLE_CMD     = 3'd0;
  localparam logic [2:0] ROLE_KEY_LEN = 3'd1;
  localparam logic [2:0] ROLE_KEY     = 3'd2;
  localparam logic [2:0] ROLE_VAL_LEN = 3'd3;
  localparam logic [2:0] ROLE_VAL     = 3'd4;

  // Configuration register indexes
  localparam logic CFG_MAX_KEY   = 1'b0;
  localparam logic CFG_MAX_VALUE = 1'b1;

  typedef struct packed {
    logic [7:0]  byte_data;
    logic [2:0]  byte_role;
    logic [7:0]  command_code;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic        last_of_part;
    logic        frame_done;
    logic        length_error;
  } result_t;

endpackage

// File: sv/lprd_in_if.sv
interface lprd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: sv/lprd_out_if.sv
interface lprd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_data;
  logic [2:0]  byte_role;
  logic [7:0]  command_code;
  logic [31:0] key_length;
  logic [31:0] value_length;
  logic        last_of_part;
  logic        frame_done;
  logic        length_error;

  modport source (
    output valid, output byte_data, output byte_role, output command_code,
    output key_length, output value_length, output last_of_part,
    output frame_done, output length_error, input ready
  );
  modport sink (
    input valid, input byte_data, input byte_role, input command_code,
    input key_length, input value_length, input last_of_part,
    input frame_done, input length_error, output ready
  );
endinterface

// File: sv/lprd_parse.sv
`include "assert_macros.svh"

// Frame parser: phase state plus the per-word result, computed in one pass.
module lprd_parse #(
  parameter int LENGTH_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  input  logic [31:0]       max_key_length,
  input  logic [31:0]       max_value_length,
  output lprd_pkg::result_t res
);

  localparam int CntW = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(LENGTH_BYTES - 1);

  localparam logic [2:0] PH_COMMAND = 3'd0;
  localparam logic [2:0] PH_KEY_LEN = 3'd1;
  localparam logic [2:0] PH_KEY     = 3'd2;
  localparam logic [2:0] PH_VAL_LEN = 3'd3;
  localparam logic [2:0] PH_VAL     = 3'd4;

  logic [2:0]      phase_r, phase_nxt;
  logic [7:0]      cmd_r, cmd_nxt;
  logic [31:0]     shift_r, shift_nxt;
  logic [CntW-1:0] seen_r, seen_nxt;
  logic [31:0]     remain_r, remain_nxt;
  logic [31:0]     key_len_r, key_len_nxt;
  logic [31:0]     val_len_r, val_len_nxt;

  logic        is_key;
  logic [31:0] shift_cat;
  logic [31:0] lim;
  logic [31:0] remain_dec;
  logic [2:0]  role;
  logic        last, done, err;

  always_comb begin
    phase_nxt   = phase_r;
    cmd_nxt     = cmd_r;
    shift_nxt   = shift_r;
    seen_nxt    = seen_r;
    remain_nxt  = remain_r;
    key_len_nxt = key_len_r;
    val_len_nxt = val_len_r;
    role        = lprd_pkg::ROLE_CMD;
    last        = 1'b0;
    done        = 1'b0;
    err         = 1'b0;
    is_key      = (phase_r == PH_KEY_LEN) || (phase_r == PH_KEY);
    shift_cat   = {shift_r[23:0], rx_byte};
    lim         = is_key ? max_key_length : max_value_length;
    remain_dec  = remain_r - {31'd0, (remain_r != 32'd0)};

    unique case (phase_r)
      PH_KEY_LEN, PH_VAL_LEN: begin
        role = is_key ? lprd_pkg::ROLE_KEY_LEN : lprd_pkg::ROLE_VAL_LEN;
        if (seen_r == LastCnt) begin
          seen_nxt  = '0;
          shift_nxt = '0;
          if (is_key) key_len_nxt = shift_cat;
          else        val_len_nxt = shift_cat;
          if (shift_cat > lim) begin
            err       = 1'b1;
            done      = 1'b1;
            phase_nxt = PH_COMMAND;
          end else if (shift_cat == 32'd0) begin
            last = 1'b1;
            if (is_key && (cmd_r == lprd_pkg::CMD_STORE)) begin
              phase_nxt = PH_VAL_LEN;
            end else begin
              done      = 1'b1;
              phase_nxt = PH_COMMAND;
            end
          end else begin
            remain_nxt = shift_cat;
            phase_nxt  = is_key ? PH_KEY : PH_VAL;
          end
        end else begin
          seen_nxt  = seen_r + CntW'(1);
          shift_nxt = shift_cat;
        end
      end
      PH_KEY, PH_VAL: begin
        role       = is_key ? lprd_pkg::ROLE_KEY : lprd_pkg::ROLE_VAL;
        remain_nxt = remain_dec;
        if (remain_dec == 32'd0) begin
          last = 1'b1;
          if (is_key && (cmd_r == lprd_pkg::CMD_STORE)) begin
            phase_nxt = PH_VAL_LEN;
            shift_nxt = '0;
            seen_nxt  = '0;
          end else begin
            done      = 1'b1;
            phase_nxt = PH_COMMAND;
          end
        end
      end
      default: begin
        // command byte; unused phase codes also land here
        cmd_nxt     = rx_byte;
        key_len_nxt = '0;
        val_len_nxt = '0;
        shift_nxt   = '0;
        seen_nxt    = '0;
        remain_nxt  = '0;
        if ((rx_byte == lprd_pkg::CMD_STORE) || (rx_byte == lprd_pkg::CMD_FETCH) ||
            (rx_byte == lprd_pkg::CMD_DELETE)) begin
          phase_nxt = PH_KEY_LEN;
        end else begin
          phase_nxt = PH_COMMAND;
          done      = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    res.byte_data    = rx_byte;
    res.byte_role    = role;
    res.command_code = cmd_nxt;
    res.key_length   = key_len_nxt;
    res.value_length = val_len_nxt;
    res.last_of_part = last;
    res.frame_done   = done;
    res.length_error = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_COMMAND;
      cmd_r     <= '0;
      shift_r   <= '0;
      seen_r    <= '0;
      remain_r  <= '0;
      key_len_r <= '0;
      val_len_r <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      cmd_r     <= cmd_nxt;
      shift_r   <= shift_nxt;
      seen_r    <= seen_nxt;
      remain_r  <= remain_nxt;
      key_len_r <= key_len_nxt;
      val_len_r <= val_len_nxt;
    end
  end

  `LPRD_NEVER(a_err_ends_frame, clk, rst_n, err && !done, "length error without frame end")
  `LPRD_NEVER(a_err_on_len_byte, clk, rst_n,
    err && (role != lprd_pkg::ROLE_KEY_LEN) && (role != lprd_pkg::ROLE_VAL_LEN),
    "length error outside a length byte")
  `LPRD_ASSERT(a_done_to_cmd, clk, rst_n, accept && done |=> phase_r == PH_COMMAND,
    "frame ended but parser not back in command phase")

endmodule

// File: sv/lprd_out_buf.sv
`include "assert_macros.svh"

// Two-entry result buffer: output register plus one skid slot.
module lprd_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lprd_pkg::result_t push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lprd_pkg::result_t out_data
);

  logic              out_valid_r;
  lprd_pkg::result_t out_data_r;
  logic              skid_valid_r;
  lprd_pkg::result_t skid_data_r;
  logic              pop;

  assign pop        = out_valid_r && out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  `LPRD_NEVER(a_skid_needs_out, clk, rst_n, skid_valid_r && !out_valid_r,
    "skid slot full while output register empty")
  `LPRD_ASSERT(a_stall_fills_skid, clk, rst_n,
    out_valid_r && !out_ready && push |=> skid_valid_r,
    "word taken during stall not held in skid slot")

endmodule

// File: sv/length_prefixed_request_deframer.sv
// Length-prefixed request deframer. Takes one received byte per word on the
// input channel and returns exactly one word per byte on the result channel,
// tagging it with its role in the frame (command, key length, key, value
// length, value), the command of the current frame, the decoded key and value
// lengths (zero until their last length byte has arrived), a last-of-part mark
// and a frame-done mark. Commands 11, 12 and 13 carry a big-endian key length
// of LENGTH_BYTES bytes and the key; command 11 adds a value length and the
// value; any other command is a one-byte frame. A length above cfg register 0
// (key) or 1 (value) raises length_error, ends the frame and returns the parser
// to the command phase. Throughput is one byte per clock while in_ch.ready is
// high. The parser state and the result are registered at the edge that takes
// a byte; the result enters the output register, or the skid slot while
// a result is held by back-pressure, so the two-entry buffer lets one more byte
// in; in_ch.ready drops only when both entries are full. Both length limits
// reset to all ones; the user must write them with cfg_we, cfg_index and
// cfg_wdata only while the block is idle, as the block does not enforce it.
module length_prefixed_request_deframer #(
  parameter int LENGTH_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  lprd_in_if.sink           in_ch,
  lprd_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_wdata
);

  logic [31:0]       max_key_r;
  logic [31:0]       max_value_r;
  logic              in_ready;
  logic              accept;
  lprd_pkg::result_t res;
  lprd_pkg::result_t out_data;
  logic              out_valid;

  // Length limits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_key_r   <= '1;
      max_value_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lprd_pkg::CFG_MAX_KEY:   max_key_r   <= cfg_wdata;
        lprd_pkg::CFG_MAX_VALUE: max_value_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  lprd_parse #(
    .LENGTH_BYTES(LENGTH_BYTES)
  ) u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .rx_byte         (in_ch.rx_byte),
    .max_key_length  (max_key_r),
    .max_value_length(max_value_r),
    .res             (res)
  );

  lprd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .push_ready(in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  // Result word onto the channel
  assign out_ch.valid        = out_valid;
  assign out_ch.byte_data    = out_data.byte_data;
  assign out_ch.byte_role    = out_data.byte_role;
  assign out_ch.command_code = out_data.command_code;
  assign out_ch.key_length   = out_data.key_length;
  assign out_ch.value_length = out_data.value_length;
  assign out_ch.last_of_part = out_data.last_of_part;
  assign out_ch.frame_done   = out_data.frame_done;
  assign out_ch.length_error = out_data.length_error;

endmodule

// File: sim/deframe_checker.sv
module deframe_checker #(
  parameter int LENGTH_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  lprd_in_if          in_ch,
  lprd_out_if         out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          pending,
  output int          mismatches,
  output int          words_checked,
  output int          frames_closed,
  output int          len_errors
);
  import lprd_pkg::*;

  typedef enum logic [2:0] {
    AWAIT_CMD,
    IN_KEY_LEN,
    IN_KEY,
    IN_VAL_LEN,
    IN_VAL
  } parse_phase_t;

  parse_phase_t phase;
  logic [7:0]   cur_cmd;
  logic [31:0]  len_acc;
  int           len_count;
  logic [31:0]  left;
  logic [31:0]  key_len_q;
  logic [31:0]  val_len_q;
  logic [31:0]  key_max;
  logic [31:0]  val_max;

  result_t predicted_words[$];
  int fail_count = 0;
  int checked = 0;
  int frames = 0;
  int errors = 0;

  task report(input string msg);
    fail_count++;
    if (fail_count <= 40) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report($sformatf("word %0d %s: got %0h, want %0h", checked, name, got, want));
    end
  endtask

  // key done: a store goes on to its value length, others close the frame
  task end_key(output logic done);
    if (cur_cmd == CMD_STORE) begin
      phase = IN_VAL_LEN;
      len_acc = '0;
      len_count = 0;
      done = 1'b0;
    end else begin
      phase = AWAIT_CMD;
      done = 1'b1;
    end
  endtask

  task decode_byte(input logic [7:0] b, output result_t r);
    logic [31:0] len;
    logic [31:0] lim;
    logic        is_key;
    r = '0;
    r.byte_data = b;
    case (phase)
      IN_KEY_LEN, IN_VAL_LEN: begin
        is_key = (phase == IN_KEY_LEN);
        r.byte_role = is_key ? ROLE_KEY_LEN : ROLE_VAL_LEN;
        len_acc = {len_acc[23:0], b};
        len_count++;
        if (len_count >= LENGTH_BYTES) begin
          len = len_acc;
          lim = is_key ? key_max : val_max;
          len_count = 0;
          len_acc = '0;
          if (is_key) key_len_q = len;
          else val_len_q = len;
          if (len > lim) begin
            r.length_error = 1'b1;
            r.frame_done = 1'b1;
            phase = AWAIT_CMD;
          end else if (len == 0) begin
            r.last_of_part = 1'b1;
            if (is_key) begin
              end_key(r.frame_done);
            end else begin
              r.frame_done = 1'b1;
              phase = AWAIT_CMD;
            end
          end else begin
            left = len;
            phase = is_key ? IN_KEY : IN_VAL;
          end
        end
      end
      IN_KEY, IN_VAL: begin
        is_key = (phase == IN_KEY);
        r.byte_role = is_key ? ROLE_KEY : ROLE_VAL;
        if (left != 0) left = left - 1;
        if (left == 0) begin
          r.last_of_part = 1'b1;
          if (is_key) begin
            end_key(r.frame_done);
          end else begin
            r.frame_done = 1'b1;
            phase = AWAIT_CMD;
          end
        end
      end
      default: begin
        r.byte_role = ROLE_CMD;
        cur_cmd = b;
        key_len_q = '0;
        val_len_q = '0;
        len_acc = '0;
        len_count = 0;
        left = '0;
        if (b == CMD_STORE || b == CMD_FETCH || b == CMD_DELETE) begin
          phase = IN_KEY_LEN;
        end else begin
          phase = AWAIT_CMD;
          r.frame_done = 1'b1;
        end
      end
    endcase
    r.command_code = cur_cmd;
    r.key_length = key_len_q;
    r.value_length = val_len_q;
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      phase = AWAIT_CMD;
      cur_cmd = '0;
      len_acc = '0;
      len_count = 0;
      left = '0;
      key_len_q = '0;
      val_len_q = '0;
      key_max = '1;
      val_max = '1;
      predicted_words.delete();
    end else begin
      // outgoing word first: it can never belong to a byte taken at this edge
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_words.size() == 0) begin
          report("result word arrived with nothing predicted");
        end else begin
          want = predicted_words.pop_front();
          check_field("byte_data", 32'(out_ch.byte_data), 32'(want.byte_data));
          check_field("byte_role", 32'(out_ch.byte_role), 32'(want.byte_role));
          check_field("command_code", 32'(out_ch.command_code), 32'(want.command_code));
          check_field("key_length", out_ch.key_length, want.key_length);
          check_field("value_length", out_ch.value_length, want.value_length);
          check_field("last_of_part", 32'(out_ch.last_of_part), 32'(want.last_of_part));
          check_field("frame_done", 32'(out_ch.frame_done), 32'(want.frame_done));
          check_field("length_error", 32'(out_ch.length_error), 32'(want.length_error));
          checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.rx_byte, want);
        predicted_words.push_back(want);
        frames += want.frame_done;
        errors += want.length_error;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_KEY) key_max = cfg_wdata;
        else val_max = cfg_wdata;
      end
    end
    pending <= predicted_words.size();
    mismatches <= fail_count;
    words_checked <= checked;
    frames_closed <= frames;
    len_errors <= errors;
  end

endmodule

// File: sim/testbench.sv
module testbench;
  import lprd_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          HOLD_CYCLES = 300;
  localparam logic [31:0] NO_LIMIT    = 32'hFFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  lprd_in_if  in_ch();
  lprd_out_if out_ch();

  // scoreboard status, all updated at the clock edge by the checker
  int pending;
  int mismatches;
  int words_checked;
  int frames_closed;
  int len_errors;

  int cycles = 0;
  int bytes_sent = 0;
  int phases_run = 0;

  // idling knobs, percent of cycles
  int idle_pct = 0;
  int stall_pct = 0;

  // long receiver hold-off, counted down in its own process
  logic hold_start = 1'b0;
  int   hold_left = 0;

  // limits currently loaded, mirrored so the frame builder can aim at them
  logic [31:0] key_lim = NO_LIMIT;
  logic [31:0] val_lim = NO_LIMIT;

  // set while the parser may sit mid-frame after random noise
  bit dirty = 1'b0;

  // Opening bytes at reset limits: a one-byte frame with an all-ones command,
  // then a store with a one-byte key and a two-byte value.
  logic [7:0] opening_bytes[$] = {
    8'hFF,
    CMD_STORE, 8'h00, 8'h00, 8'h00, 8'h01, 8'hA5,
    8'h00, 8'h00, 8'h00, 8'h02, 8'h5A, 8'h3C
  };

  // With key max all ones minus one and value max zero: a store whose empty
  // key ends on its last length byte without closing the frame, then an
  // oversized value length; then a delete whose all-ones key length is one
  // above the key max.
  logic [7:0] limit_bytes[$] = {
    CMD_STORE, 8'h00, 8'h00, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'hFF,
    CMD_DELETE, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  initial begin
    forever #10 clk = ~clk;
  end

  length_prefixed_request_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  deframe_checker watcher (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .pending       (pending),
    .mismatches    (mismatches),
    .words_checked (words_checked),
    .frames_closed (frames_closed),
    .len_errors    (len_errors)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // receiver: random stalls, forced low through a hold-off
  always @(posedge clk) begin
    out_ch.ready <= !hold_start && hold_left <= 1 && ($urandom_range(0, 99) >= stall_pct);
  end

  // Offer one byte and wait for the handshake. Valid stays high into the
  // next byte unless a sender gap is drawn; a gap always waits on the clock
  // before the next byte is offered, so valid is never dropped and raised in the same step.
  task automatic push_byte(input logic [7:0] b);
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.rx_byte <= 8'($urandom);
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  // Drop valid and wait for every predicted word to come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // writes both limits on back-to-back edges; cfg_we stays high between them
  task automatic load_limits(input logic [31:0] kmax, input logic [31:0] vmax);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_KEY;
    cfg_wdata <= kmax;
    @(posedge clk);
    cfg_index <= CFG_MAX_VALUE;
    cfg_wdata <= vmax;
    @(posedge clk);
    cfg_we <= 1'b0;
    key_lim = kmax;
    val_lim = vmax;
  endtask

  // Mostly short lengths; some zero, some exactly at a small limit, some
  // just over or far over it (the far-over ones exercise the high bits).
  function automatic logic [31:0] pick_length(input logic [31:0] lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 32'd0;
    if (r < 22 && lim != NO_LIMIT) begin
      if ($urandom_range(0, 1) != 0) return lim + 1;
      return $urandom_range(NO_LIMIT, lim + 1);
    end
    if (r < 30 && lim <= 16) return lim;
    if (lim == 0) return 32'd0;
    return $urandom_range(1, (lim < 12) ? lim : 12);
  endfunction

  task automatic send_frame(input bit noisy);
    logic [7:0]  frame[$];
    logic [7:0]  opcode;
    logic [31:0] klen;
    logic [31:0] vlen;
    int          keep;
    if (noisy && $urandom_range(0, 99) < 15) begin
      // raw line noise
      repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom));
    end else begin
      if ($urandom_range(0, 99) < 80) begin
        case ($urandom_range(0, 2))
          0: opcode = CMD_STORE;
          1: opcode = CMD_FETCH;
          default: opcode = CMD_DELETE;
        endcase
      end else begin
        opcode = 8'($urandom);
      end
      frame.push_back(opcode);
      if (opcode == CMD_STORE || opcode == CMD_FETCH || opcode == CMD_DELETE) begin
        klen = pick_length(key_lim);
        for (int i = 3; i >= 0; i--) frame.push_back(klen[8*i +: 8]);
        // an oversized length ends the frame right there
        if (klen <= key_lim) begin
          repeat (klen) frame.push_back(8'($urandom));
          if (opcode == CMD_STORE) begin
            vlen = pick_length(val_lim);
            for (int i = 3; i >= 0; i--) frame.push_back(vlen[8*i +: 8]);
            if (vlen <= val_lim) begin
              repeat (vlen) frame.push_back(8'($urandom));
            end
          end
        end
      end
      // now and then cut the frame short so the next one is misparsed
      if (noisy && frame.size() > 1 && $urandom_range(0, 99) < 10) begin
        keep = $urandom_range(1, frame.size() - 1);
        while (frame.size() > keep) void'(frame.pop_back());
      end
    end
    foreach (frame[i]) push_byte(frame[i]);
  endtask

  // One phase: idle the block, load limits, set idling, optionally squeeze
  // the output with a long hold-off, then stream frames. Noise is only used
  // under small limits, so a misparsed length can never lock the parser in
  // a multi-gigabyte key. Before a clean phase that follows a noisy one, a
  // run of zero bytes walks the parser back to the command phase: zero
  // lengths end their part and 0x00 is a one-byte frame.
  task automatic run_phase(input int send_idle, input int recv_stall,
                           input logic [31:0] kmax, input logic [31:0] vmax,
                           input int n, input bit noisy, input bit squeeze);
    int stop;
    if (!noisy && dirty) begin
      repeat (key_lim + val_lim + 12) push_byte(8'h00);
    end
    settle();
    load_limits(kmax, vmax);
    idle_pct = send_idle;
    stall_pct = recv_stall;
    dirty = noisy;
    phases_run++;
    if (squeeze) begin
      // sender keeps offering while the receiver is held off, so the
      // output buffer fills and in_ch.ready has to drop
      hold_start <= 1'b1;
      @(posedge clk);
      hold_start <= 1'b0;
    end
    stop = bytes_sent + n;
    while (bytes_sent < stop) send_frame(noisy);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_KEY;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset limits first
    foreach (opening_bytes[i]) push_byte(opening_bytes[i]);
    settle();
    load_limits(32'hFFFF_FFFE, 32'h0);
    foreach (limit_bytes[i]) push_byte(limit_bytes[i]);

    // random part: idling mode, key max, value max, bytes, noise, hold-off
    run_phase(0, 0, NO_LIMIT, NO_LIMIT, 100, 1'b0, 1'b0);
    run_phase(79, 0, 32'd16, 32'd8, 100, 1'b1, 1'b0);
    run_phase(0, 79, 32'd0, 32'd0, 80, 1'b1, 1'b0);
    run_phase(15, 15, 32'd255, 32'd3, 100, 1'b1, 1'b0);
    run_phase(0, 0, 32'd20, 32'd20, 80, 1'b1, 1'b1);
    run_phase(79, 0, $urandom_range(0, 30), $urandom_range(0, 30), 80, 1'b1, 1'b0);
    run_phase(0, 79, NO_LIMIT, NO_LIMIT, 100, 1'b0, 1'b0);
    run_phase(15, 15, 32'd7, 32'd255, 80, 1'b1, 1'b0);

    settle();
    $display("summary: %0d bytes sent, %0d words checked over %0d random phases",
             bytes_sent, words_checked, phases_run);
    $display("summary: %0d frames closed, %0d length errors, limits from zero to all ones",
             frames_closed, len_errors);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/lprd_pkg.sv
sv/lprd_in_if.sv
sv/lprd_out_if.sv
sv/lprd_parse.sv
sv/lprd_out_buf.sv
sv/length_prefixed_request_deframer.sv
sim/deframe_checker.sv
sim/testbench.sv
